@@ sv/ntc_pkg.sv @@
package ntc_pkg;

    localparam int DIV_BITS = 30;
    localparam int LANE_LAT = DIV_BITS + 3;

    localparam logic [30:0] NEAR_RESET = 31'd1;

    // register index, byte address is 4 times this
    localparam logic [1:0] REG_NEAR = 2'd0;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_TRI,
        MODE_QUAD
    } mode_t;

    typedef struct packed {
        logic  valid;
        mode_t mode;
    } pipe_ctl_t;

endpackage

@@ sv/near_plane_triangle_clipper.sv @@
// out_valid rises once a triangle has passed the lane registers and the output holder
// throughput: one triangle per cycle with out_ready high; a quad waits for both halves
// the rate is set by the single output holder; the dividers are pipelined, one bit a stage
// fully-behind triangles are accepted and produce no word
// rst_n (async, active low) empties the pipe and holder and sets near_plane to 1
module near_plane_triangle_clipper (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] c_x,
    input  logic signed [31:0] c_y,
    input  logic signed [31:0] c_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_a_x,
    output logic signed [31:0] out_a_y,
    output logic signed [31:0] out_a_z,
    output logic signed [31:0] out_b_x,
    output logic signed [31:0] out_b_y,
    output logic signed [31:0] out_b_z,
    output logic signed [31:0] out_c_x,
    output logic signed [31:0] out_c_y,
    output logic signed [31:0] out_c_z,
    output logic               last_triangle
);
    import ntc_pkg::*;

    logic [30:0] near_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            near_reg <= NEAR_RESET;
        else if (psel && penable && pwrite && (paddr[3:2] == REG_NEAR))
            near_reg <= pwdata[30:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[3:2] == REG_NEAR) ? {1'b0, near_reg} : 32'd0;

    vec_t        v [0:2];
    logic [2:0]  f, bk;
    logic signed [32:0] near_s;
    vec_t        r0, r1, r2;
    logic        fr0, fr2, all_front, drop;
    vec_t        l0_x, l0_y, l1_x, l1_y;
    mode_t       mode_in;
    logic        adv, accept;

    always_comb
    begin
        v[0] = '{x: a_x, y: a_y, z: a_z};
        v[1] = '{x: b_x, y: b_y, z: b_z};
        v[2] = '{x: c_x, y: c_y, z: c_z};
        near_s = $signed({2'b00, near_reg});
        for (int i = 0; i < 3; i++)
        begin
            f[i]  = $signed({v[i].z[31], v[i].z}) > near_s;
            bk[i] = $signed({v[i].z[31], v[i].z}) < near_s;
        end
        all_front = &f;
        // first rotation that puts a front vertex before a behind one
        if (f[0] && bk[1])
        begin
            r0 = v[0]; r1 = v[1]; r2 = v[2]; fr0 = f[0]; fr2 = f[2];
        end
        else if (f[2] && bk[0])
        begin
            r0 = v[2]; r1 = v[0]; r2 = v[1]; fr0 = f[2]; fr2 = f[1];
        end
        else if (f[1] && bk[2])
        begin
            r0 = v[1]; r1 = v[2]; r2 = v[0]; fr0 = f[1]; fr2 = f[0];
        end
        else
        begin
            r0 = v[0]; r1 = v[1]; r2 = v[2]; fr0 = f[0]; fr2 = f[2];
        end
        drop = !all_front && !fr0;
        l0_x = r0;
        l0_y = r1;
        l1_x = fr2 ? r2 : r0;
        l1_y = fr2 ? r1 : r2;
        if (all_front)
        begin
            // zero-length segment gives back the middle vertex
            l0_x = v[1];
            l0_y = v[1];
            mode_in = MODE_PASS;
        end
        else if (fr2)
            mode_in = MODE_QUAD;
        else
            mode_in = MODE_TRI;
    end

    assign in_ready = adv;
    assign accept = in_valid && adv;

    logic  side_valid_reg [0:LANE_LAT-1];
    mode_t side_mode_reg  [0:LANE_LAT-1];
    vec_t  side_r0_reg    [0:LANE_LAT-1];
    vec_t  side_r2_reg    [0:LANE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LANE_LAT; s++)
            begin
                side_valid_reg[s] <= 1'b0;
                side_mode_reg[s]  <= MODE_PASS;
            end
        end
        else if (adv)
        begin
            side_valid_reg[0] <= accept && !drop;
            side_mode_reg[0]  <= mode_in;
            for (int s = 1; s < LANE_LAT; s++)
            begin
                side_valid_reg[s] <= side_valid_reg[s-1];
                side_mode_reg[s]  <= side_mode_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_r0_reg[0] <= all_front ? v[0] : r0;
            side_r2_reg[0] <= all_front ? v[2] : r2;
            for (int s = 1; s < LANE_LAT; s++)
            begin
                side_r0_reg[s] <= side_r0_reg[s-1];
                side_r2_reg[s] <= side_r2_reg[s-1];
            end
        end
    end

    vec_t p_pt, q_pt;

    ntc_lane u_lane0 (
        .clk        (clk),
        .en         (adv),
        .vx         (l0_x),
        .vy         (l0_y),
        .near_plane (near_reg),
        .pt         (p_pt)
    );

    ntc_lane u_lane1 (
        .clk        (clk),
        .en         (adv),
        .vx         (l1_x),
        .vy         (l1_y),
        .near_plane (near_reg),
        .pt         (q_pt)
    );

    pipe_ctl_t end_ctl;
    vec_t      o_a, o_b, o_c;

    assign end_ctl = '{valid: side_valid_reg[LANE_LAT-1], mode: side_mode_reg[LANE_LAT-1]};

    ntc_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (end_ctl),
        .r0        (side_r0_reg[LANE_LAT-1]),
        .r2        (side_r2_reg[LANE_LAT-1]),
        .p         (p_pt),
        .q         (q_pt),
        .adv       (adv),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .o_a       (o_a),
        .o_b       (o_b),
        .o_c       (o_c),
        .o_last    (last_triangle)
    );

    assign out_a_x = o_a.x;
    assign out_a_y = o_a.y;
    assign out_a_z = o_a.z;
    assign out_b_x = o_b.x;
    assign out_b_y = o_b.y;
    assign out_b_z = o_b.z;
    assign out_c_x = o_c.x;
    assign out_c_y = o_c.y;
    assign out_c_z = o_c.z;

    a_stall_holds_end: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(side_valid_reg[LANE_LAT-1]))
        else $error("pipe end moved during stall");

    a_drop_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && drop) |=> !side_valid_reg[0])
        else $error("fully behind triangle entered pipe");

    a_pass_all_front: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && all_front) |=> (side_mode_reg[0] == MODE_PASS))
        else $error("front triangle not passed");

endmodule

@@ sv/ntc_lane.sv @@
module ntc_lane (
    input  logic          clk,
    input  logic          en,
    input  ntc_pkg::vec_t vx,
    input  ntc_pkg::vec_t vy,
    input  logic [30:0]   near_plane,
    output ntc_pkg::vec_t pt
);
    import ntc_pkg::*;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } diff_t;

    typedef struct packed {
        logic signed [64:0] x;
        logic signed [64:0] y;
        logic signed [64:0] z;
    } prod_t;

    localparam logic [DIV_BITS:0] T_ONE = (DIV_BITS+1)'(1) << DIV_BITS;
    localparam logic signed [64:0] RND = (65'sd1 <<< DIV_BITS) - 65'sd1;

    function automatic logic signed [31:0] interp(logic signed [64:0] prod,
                                                  logic signed [31:0] base);
        logic signed [64:0] adj;
        logic signed [64:0] sh;
        begin
            // truncate toward zero
            adj = prod[64] ? prod + RND : prod;
            sh = adj >>> DIV_BITS;
            return base + sh[31:0];
        end
    endfunction

    logic signed [33:0] num;
    logic signed [32:0] den;
    logic [31:0]        an;
    logic [31:0]        ad;
    logic               zero_t;
    logic               full_t;
    diff_t              dif;

    always_comb
    begin
        num = $signed({3'b000, near_plane}) - $signed({{2{vy.z[31]}}, vy.z});
        den = $signed({vx.z[31], vx.z}) - $signed({vy.z[31], vy.z});
        an = num[33] ? 32'(-num) : num[31:0];
        ad = den[32] ? 32'(-den) : den[31:0];
        zero_t = (den == '0) || (num == '0) || (num[33] != den[32]);
        full_t = !zero_t && (an >= ad);
        dif.x = $signed({vx.x[31], vx.x}) - $signed({vy.x[31], vy.x});
        dif.y = $signed({vx.y[31], vx.y}) - $signed({vy.y[31], vy.y});
        dif.z = $signed({vx.z[31], vx.z}) - $signed({vy.z[31], vy.z});
    end

    logic [31:0]         rem_reg  [0:DIV_BITS];
    logic [DIV_BITS-1:0] q_reg    [0:DIV_BITS];
    logic [31:0]         ad_reg   [0:DIV_BITS];
    logic                zero_reg [0:DIV_BITS];
    logic                full_reg [0:DIV_BITS];
    diff_t               dif_reg  [0:DIV_BITS];
    vec_t                vy_reg   [0:DIV_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= an;
            q_reg[0]    <= '0;
            ad_reg[0]   <= ad;
            zero_reg[0] <= zero_t;
            full_reg[0] <= full_t;
            dif_reg[0]  <= dif;
            vy_reg[0]   <= vy;
        end
    end

    // one quotient bit per stage
    for (genvar s = 1; s <= DIV_BITS; s++)
    begin : g_div
        logic [32:0] rem2;
        logic        ge;
        logic [32:0] rem_sub;

        always_comb
        begin
            rem2 = {rem_reg[s-1], 1'b0};
            ge = rem2 >= {1'b0, ad_reg[s-1]};
            rem_sub = ge ? rem2 - {1'b0, ad_reg[s-1]} : rem2;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_sub[31:0];
                q_reg[s]    <= {q_reg[s-1][DIV_BITS-2:0], ge};
                ad_reg[s]   <= ad_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                full_reg[s] <= full_reg[s-1];
                dif_reg[s]  <= dif_reg[s-1];
                vy_reg[s]   <= vy_reg[s-1];
            end
        end
    end

    logic [DIV_BITS:0]  t_val;
    logic signed [31:0] t_s;
    prod_t              prod_reg;
    vec_t               vy_m_reg;
    vec_t               pt_reg;

    always_comb
    begin
        if (zero_reg[DIV_BITS])
            t_val = '0;
        else if (full_reg[DIV_BITS])
            t_val = T_ONE;
        else
            t_val = {1'b0, q_reg[DIV_BITS]};
        t_s = $signed(32'(t_val));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg.x <= dif_reg[DIV_BITS].x * t_s;
            prod_reg.y <= dif_reg[DIV_BITS].y * t_s;
            prod_reg.z <= dif_reg[DIV_BITS].z * t_s;
            vy_m_reg   <= vy_reg[DIV_BITS];
            pt_reg.x   <= interp(prod_reg.x, vy_m_reg.x);
            pt_reg.y   <= interp(prod_reg.y, vy_m_reg.y);
            pt_reg.z   <= interp(prod_reg.z, vy_m_reg.z);
        end
    end

    assign pt = pt_reg;

endmodule

@@ sv/ntc_merge.sv @@
module ntc_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  ntc_pkg::pipe_ctl_t ctl,
    input  ntc_pkg::vec_t      r0,
    input  ntc_pkg::vec_t      r2,
    input  ntc_pkg::vec_t      p,
    input  ntc_pkg::vec_t      q,
    output logic               adv,
    output logic               out_valid,
    input  logic               out_ready,
    output ntc_pkg::vec_t      o_a,
    output ntc_pkg::vec_t      o_b,
    output ntc_pkg::vec_t      o_c,
    output logic               o_last
);
    import ntc_pkg::*;

    logic  full_reg, full_next;
    logic  phase_reg, phase_next;
    mode_t mode_reg;
    vec_t  r0_reg, r2_reg, p_reg, q_reg;
    logic  take, load;

    always_comb
    begin
        o_last = (mode_reg != MODE_QUAD) || phase_reg;
        case (mode_reg)
            MODE_TRI:
            begin
                o_a = r0_reg;
                o_b = p_reg;
                o_c = q_reg;
            end
            MODE_QUAD:
            begin
                o_a = phase_reg ? p_reg : r0_reg;
                o_b = phase_reg ? q_reg : p_reg;
                o_c = r2_reg;
            end
            default:
            begin
                o_a = r0_reg;
                o_b = p_reg;
                o_c = r2_reg;
            end
        endcase
        out_valid = full_reg;
        take = full_reg && out_ready;
        // pipe moves when the holder frees up or its last stage is empty
        adv = !full_reg || (take && o_last) || !ctl.valid;
        load = adv && ctl.valid;
        full_next = full_reg;
        phase_next = phase_reg;
        if (take)
        begin
            if (o_last)
                full_next = 1'b0;
            else
                phase_next = 1'b1;
        end
        if (load)
        begin
            full_next = 1'b1;
            phase_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg  <= 1'b0;
            phase_reg <= 1'b0;
            mode_reg  <= MODE_PASS;
        end
        else
        begin
            full_reg  <= full_next;
            phase_reg <= phase_next;
            if (load)
                mode_reg <= ctl.mode;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r0_reg <= r0;
            r2_reg <= r2;
            p_reg  <= p;
            q_reg  <= q;
        end
    end

    a_first_then_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !o_last) |=> (out_valid && o_last))
        else $error("second quad triangle did not follow");

    a_nonlast_is_quad: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !o_last) |-> (mode_reg == MODE_QUAD))
        else $error("non-final word outside quad");

    a_no_load_over_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && !take) |-> !load)
        else $error("holder overwritten");

endmodule
